// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the I2C bit engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/i2cmbe_pkg.sv =====
// Package of the I2C bit engine: item layout, command codes and phase length codes.
package i2cmbe_pkg;

	// input item fields
	localparam int ACTION_W   = 3;
	localparam int BYTE_W     = 8;
	localparam int IN_BITS    = ACTION_W + BYTE_W + 2;   // 13
	localparam int IN_TDATA_W = 16;
	localparam int OUT_BITS   = 5 + BYTE_W + 1;          // 14
	localparam int OUT_TDATA_W = 16;
	localparam int COUNT_W    = 8;
	localparam int BITS_W     = 4;

	// bit positions in s_tdata
	localparam int IN_ACTION_LSB = 0;
	localparam int IN_WBYTE_LSB  = 3;
	localparam int IN_NACK_BIT   = 11;
	localparam int IN_SDA_BIT    = 12;

	// bit positions in m_tdata
	localparam int OUT_SCL_BIT   = 0;
	localparam int OUT_SDA_BIT   = 1;
	localparam int OUT_EN_BIT    = 2;
	localparam int OUT_BUSY_BIT  = 3;
	localparam int OUT_DONE_BIT  = 4;
	localparam int OUT_RBYTE_LSB = 5;
	localparam int OUT_ACK_BIT   = 13;

	// command codes
	localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

	localparam logic [BITS_W-1:0]  BITS_PER_BYTE = 4'd8;
	localparam logic [COUNT_W-1:0] LAST_FOUR     = 8'd3;   // four-tick closing phase

	typedef enum logic [1:0] {
		LEN_T,      // phase_ticks+1 ticks
		LEN_ONE,    // single tick
		LEN_FOUR    // four ticks
	} phase_len_t;

endpackage

// ===== hdl/i2c_master_bit_engine.sv =====
// Top level of the I2C bit engine: tick-driven start/stop/write/read sequencer.
// An accepted item is held in the input stage, then its result in the result register that
// drives m_tdata. Throughput: one item per cycle unless m_tready stalls the result; the rate is
// set by the single-pass step logic between the input stage and the result register.
// Reset (arst_n low, asynchronous): sequencer idle, SCL/SDA levels high, SDA released,
// counters, shift byte, read byte, ack flag and phase_ticks cleared, both stages empty.
module i2c_master_bit_engine
	import i2cmbe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata, LSB up: action[2:0], write_byte[10:3], send_nack[11], sda_level[12], zero[15:13]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata, LSB up: scl_drive[0], sda_drive[1], sda_enable[2], busy_res[3],
	// done_res[4], read_byte[12:5], ack_seen[13], zero[15:14]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// phase_ticks register
	input  logic                   cfg_we,
	input  logic [COUNT_W-1:0]     cfg_wdata
);

	// Sequencer steps, one per bus phase.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START1, ST_START2, ST_START3, ST_START4,
		ST_STOP1, ST_STOP2,
		ST_WR_BIT, ST_WR_HIGH, ST_WR_LOW, ST_WA_REL, ST_WA_HIGH, ST_WR_DONE,
		ST_RD_HIGH, ST_RD_LOW, ST_RA_DRIVE, ST_RA_HIGH, ST_RA_DONE
	} step_t;

	// ---------------- input stage ----------------
	logic                 valid_s1;
	logic [IN_BITS-1:0]   data_s1;
	logic                 adv;      // result register can take a new item

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata[IN_BITS-1:0];
		end
	end

	logic [ACTION_W-1:0] action;
	logic [BYTE_W-1:0]   write_byte;
	logic                send_nack;
	logic                sda_level;

	assign action     = data_s1[IN_ACTION_LSB +: ACTION_W];
	assign write_byte = data_s1[IN_WBYTE_LSB +: BYTE_W];
	assign send_nack  = data_s1[IN_NACK_BIT];
	assign sda_level  = data_s1[IN_SDA_BIT];

	// ---------------- configuration ----------------
	logic [COUNT_W-1:0] phase_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= '0;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// ---------------- sequencer state ----------------
	step_t              step_q;
	logic [BITS_W-1:0]  bits_q;
	logic [BYTE_W-1:0]  shift_q;
	logic [COUNT_W-1:0] count_q;
	logic               nack_q;
	logic               ack_q;
	logic               scl_q;
	logic               sda_q;
	logic               en_q;
	logic [BYTE_W-1:0]  rbyte_q;
	logic               busy_q;
	logic               done_q;
	logic               out_valid_q;

	// next-state values for one tick
	step_t              n_step;
	logic [BITS_W-1:0]  n_bits;
	logic [BYTE_W-1:0]  n_shift;
	logic [COUNT_W-1:0] n_count;
	logic               n_nack;
	logic               n_ack;
	logic               n_scl;
	logic               n_sda;
	logic               n_en;
	logic [BYTE_W-1:0]  n_rbyte;
	logic               n_busy;
	logic               n_done;
	phase_len_t         len;
	logic [COUNT_W-1:0] last_cnt;

	always_comb begin
		n_step  = step_q;
		n_bits  = bits_q;
		n_shift = shift_q;
		n_count = count_q;
		n_nack  = nack_q;
		n_ack   = ack_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_en    = en_q;
		n_rbyte = rbyte_q;
		n_busy  = 1'b0;
		n_done  = 1'b0;
		len     = LEN_ONE;

		// command decode: only taken when idle, the accepting tick runs the first phase
		if (step_q == ST_IDLE) begin
			n_count = '0;
			case (action)
				ACT_START: n_step = ST_START1;
				ACT_STOP:  n_step = ST_STOP1;
				ACT_WRITE: begin
					n_shift = write_byte;
					n_bits  = BITS_PER_BYTE;
					n_step  = ST_WR_BIT;
				end
				ACT_READ: begin
					n_shift = '0;
					n_bits  = BITS_PER_BYTE;
					n_nack  = send_nack;
					n_step  = ST_RD_HIGH;
				end
				default: n_step = ST_IDLE;
			endcase
		end

		// drive levels of the current phase
		case (n_step)
			ST_START1:   begin n_sda = 1'b1; n_en = 1'b1; len = LEN_T; end
			ST_START2:   begin n_scl = 1'b1; len = LEN_ONE; end
			ST_START3:   begin n_sda = 1'b0; len = LEN_T; end
			ST_START4:   begin n_scl = 1'b0; len = LEN_ONE; end
			ST_STOP1:    begin n_scl = 1'b1; len = LEN_T; end
			ST_STOP2:    begin n_sda = 1'b1; len = LEN_T; end
			ST_WR_BIT:   begin n_sda = n_shift[BYTE_W-1]; n_en = 1'b1; len = LEN_T; end
			ST_WR_HIGH:  begin n_scl = 1'b1; len = LEN_T; end
			ST_WR_LOW:   begin n_scl = 1'b0; len = LEN_T; end
			ST_WA_REL:   begin n_en = 1'b0; len = LEN_T; end
			ST_WA_HIGH:  begin n_scl = 1'b1; len = LEN_T; end
			ST_WR_DONE:  begin n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1; len = LEN_ONE; end
			ST_RD_HIGH:  begin n_scl = 1'b1; n_en = 1'b0; len = LEN_T; end
			ST_RD_LOW:   begin n_scl = 1'b0; len = LEN_T; end
			ST_RA_DRIVE: begin n_sda = n_nack; n_en = 1'b1; len = LEN_T; end
			ST_RA_HIGH:  begin n_scl = 1'b1; len = LEN_T; end
			ST_RA_DONE:  begin n_scl = 1'b0; n_sda = 1'b0; len = LEN_FOUR; end
			default:     len = LEN_ONE;
		endcase

		case (len)
			LEN_T:    last_cnt = phase_ticks_q;
			LEN_FOUR: last_cnt = LAST_FOUR;
			default:  last_cnt = '0;
		endcase

		if (n_step != ST_IDLE) begin
			n_busy = 1'b1;
			if (n_count < last_cnt) begin
				n_count = n_count + 1'b1;
			end else begin
				n_count = '0;
				// end-of-phase action
				case (n_step)
					ST_START1:  n_step = ST_START2;
					ST_START2:  n_step = ST_START3;
					ST_START3:  n_step = ST_START4;
					ST_STOP1:   n_step = ST_STOP2;
					ST_WR_BIT:  n_step = ST_WR_HIGH;
					ST_WR_HIGH: n_step = ST_WR_LOW;
					ST_WR_LOW: begin
						n_shift = {n_shift[BYTE_W-2:0], 1'b0};
						if (n_bits != '0) n_bits = n_bits - 1'b1;
						n_step = (n_bits != '0) ? ST_WR_BIT : ST_WA_REL;
					end
					ST_WA_REL:  n_step = ST_WA_HIGH;
					ST_WA_HIGH: begin
						n_ack  = sda_level;       // slave ack sampled on last SCL-high tick
						n_step = ST_WR_DONE;
					end
					ST_RD_HIGH: begin
						n_shift = {n_shift[BYTE_W-2:0], sda_level};
						if (n_bits != '0) n_bits = n_bits - 1'b1;
						n_step = ST_RD_LOW;
					end
					ST_RD_LOW:   n_step = (n_bits != '0) ? ST_RD_HIGH : ST_RA_DRIVE;
					ST_RA_DRIVE: n_step = ST_RA_HIGH;
					ST_RA_HIGH:  n_step = ST_RA_DONE;
					ST_RA_DONE: begin
						n_rbyte = n_shift;
						n_done  = 1'b1;
						n_step  = ST_IDLE;
					end
					default: begin
						// closing phase of start, stop or write
						n_done = 1'b1;
						n_step = ST_IDLE;
					end
				endcase
			end
		end
	end

	// state and result register, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			bits_q      <= '0;
			shift_q     <= '0;
			count_q     <= '0;
			nack_q      <= 1'b0;
			ack_q       <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			en_q        <= 1'b0;
			rbyte_q     <= '0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				step_q  <= n_step;
				bits_q  <= n_bits;
				shift_q <= n_shift;
				count_q <= n_count;
				nack_q  <= n_nack;
				ack_q   <= n_ack;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				en_q    <= n_en;
				rbyte_q <= n_rbyte;
				busy_q  <= n_busy;
				done_q  <= n_done;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, ack_q, rbyte_q,
		done_q, busy_q, en_q, sda_q, scl_q};

endmodule

// ===== hdl/i2cmbe_checker.sv =====
// Port-level checker of the I2C bit engine and its bind to the top level.
`include "assert_macros.svh"

module i2cmbe_checker
	import i2cmbe_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// a completing tick is always a busy tick
	`ASSERT_IMPL(a_done_busy, m_tvalid && m_tdata[OUT_DONE_BIT], m_tdata[OUT_BUSY_BIT])

	// with the result register empty the input side never stalls
	`ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready)

	// a stalled result item holds
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_i2cmbe_checker (.*);

// ===== tb/sv/i2cmbe_tb_pkg.sv =====
// Bus level tracker for the I2C bit engine bench: its own sequencer copy plus the queue of expected levels.
`timescale 1ns / 1ps

package i2cmbe_tb_pkg;
	import i2cmbe_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

	typedef enum logic [4:0] {
		SEQ_IDLE,
		SEQ_START_SDA_HI, SEQ_START_SCL_HI, SEQ_START_SDA_LO, SEQ_START_SCL_LO,
		SEQ_STOP_SCL_HI, SEQ_STOP_SDA_HI,
		SEQ_WR_BIT, SEQ_WR_SCL_HI, SEQ_WR_SCL_LO,
		SEQ_WA_RELEASE, SEQ_WA_SCL_HI, SEQ_WA_DONE,
		SEQ_RD_SCL_HI, SEQ_RD_SCL_LO,
		SEQ_RA_DRIVE, SEQ_RA_SCL_HI, SEQ_RA_CLOSE
	} seq_step_t;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              en;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] rbyte;
		logic              ack;
	} bus_tick_t;

	class bus_level_board;
		logic [COUNT_W-1:0] phase_ticks;
		seq_step_t          step;
		logic [BITS_W-1:0]  bits_left;
		logic [BYTE_W-1:0]  shift_byte;
		logic [COUNT_W-1:0] phase_count;
		logic               nack_choice;
		logic               ack_flag;
		logic               scl_level;
		logic               sda_level;
		logic               sda_en;
		logic [BYTE_W-1:0]  read_hold;

		bus_tick_t expected_levels[$];

		int unsigned mismatches;
		int unsigned compared;
		int unsigned busy_ticks;
		int unsigned starts, stops, writes, reads;

		function new();
			phase_ticks = '0;
			step        = SEQ_IDLE;
			bits_left   = '0;
			shift_byte  = '0;
			phase_count = '0;
			nack_choice = 1'b0;
			ack_flag    = 1'b0;
			scl_level   = 1'b1;
			sda_level   = 1'b1;
			sda_en      = 1'b0;
			read_hold   = '0;
			mismatches  = 0;
			compared    = 0;
			busy_ticks  = 0;
			starts = 0; stops = 0; writes = 0; reads = 0;
		endfunction

		function void set_phase_ticks(logic [COUNT_W-1:0] v);
			phase_ticks = v;
		endfunction

		function bit is_busy();
			return step != SEQ_IDLE;
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction

		// one accepted tick: advance the sequencer copy and queue the levels it leaves
		function void tick_accepted(logic [IN_TDATA_W-1:0] d);
			logic [ACTION_W-1:0] act;
			logic [BYTE_W-1:0]   wbyte;
			logic                nack;
			logic                sda_in;
			logic                busy;
			logic                done;
			phase_len_t          len;
			logic [COUNT_W-1:0]  last;
			bus_tick_t           t;

			act    = d[IN_ACTION_LSB +: ACTION_W];
			wbyte  = d[IN_WBYTE_LSB +: BYTE_W];
			nack   = d[IN_NACK_BIT];
			sda_in = d[IN_SDA_BIT];
			busy   = 1'b0;
			done   = 1'b0;
			len    = LEN_T;

			if (step == SEQ_IDLE) begin
				phase_count = '0;
				case (act)
					ACT_START: begin
						step = SEQ_START_SDA_HI;
						starts++;
					end
					ACT_STOP: begin
						step = SEQ_STOP_SCL_HI;
						stops++;
					end
					ACT_WRITE: begin
						shift_byte = wbyte;
						bits_left  = BITS_PER_BYTE;
						step       = SEQ_WR_BIT;
						writes++;
					end
					ACT_READ: begin
						shift_byte  = '0;
						bits_left   = BITS_PER_BYTE;
						nack_choice = nack;
						step        = SEQ_RD_SCL_HI;
						reads++;
					end
					default: ;
				endcase
			end

			if (step != SEQ_IDLE) begin
				busy = 1'b1;
				busy_ticks++;
				case (step)
					SEQ_START_SDA_HI: begin sda_level = 1'b1; sda_en = 1'b1; end
					SEQ_START_SCL_HI: begin scl_level = 1'b1; len = LEN_ONE; end
					SEQ_START_SDA_LO: sda_level = 1'b0;
					SEQ_START_SCL_LO: begin scl_level = 1'b0; len = LEN_ONE; end
					SEQ_STOP_SCL_HI:  scl_level = 1'b1;
					SEQ_STOP_SDA_HI:  sda_level = 1'b1;
					SEQ_WR_BIT:       begin sda_level = shift_byte[BYTE_W-1]; sda_en = 1'b1; end
					SEQ_WR_SCL_HI:    scl_level = 1'b1;
					SEQ_WR_SCL_LO:    scl_level = 1'b0;
					SEQ_WA_RELEASE:   sda_en = 1'b0;
					SEQ_WA_SCL_HI:    scl_level = 1'b1;
					SEQ_WA_DONE: begin
						scl_level = 1'b0;
						sda_level = 1'b0;
						sda_en    = 1'b1;
						len       = LEN_ONE;
					end
					SEQ_RD_SCL_HI:    begin scl_level = 1'b1; sda_en = 1'b0; end
					SEQ_RD_SCL_LO:    scl_level = 1'b0;
					SEQ_RA_DRIVE:     begin sda_level = nack_choice; sda_en = 1'b1; end
					SEQ_RA_SCL_HI:    scl_level = 1'b1;
					SEQ_RA_CLOSE: begin
						scl_level = 1'b0;
						sda_level = 1'b0;
						len       = LEN_FOUR;
					end
					default: ;
				endcase

				case (len)
					LEN_T:   last = phase_ticks;
					LEN_ONE: last = '0;
					default: last = LAST_FOUR;
				endcase

				// a count already past a freshly lowered phase_ticks ends the phase too
				if (phase_count < last) begin
					phase_count = phase_count + 1'b1;
				end else begin
					phase_count = '0;
					case (step)
						SEQ_START_SDA_HI: step = SEQ_START_SCL_HI;
						SEQ_START_SCL_HI: step = SEQ_START_SDA_LO;
						SEQ_START_SDA_LO: step = SEQ_START_SCL_LO;
						SEQ_STOP_SCL_HI:  step = SEQ_STOP_SDA_HI;
						SEQ_WR_BIT:       step = SEQ_WR_SCL_HI;
						SEQ_WR_SCL_HI:    step = SEQ_WR_SCL_LO;
						SEQ_WR_SCL_LO: begin
							shift_byte = shift_byte << 1;
							if (bits_left != '0) bits_left = bits_left - 1'b1;
							step = (bits_left != '0) ? SEQ_WR_BIT : SEQ_WA_RELEASE;
						end
						SEQ_WA_RELEASE:   step = SEQ_WA_SCL_HI;
						SEQ_WA_SCL_HI: begin
							ack_flag = sda_in;
							step     = SEQ_WA_DONE;
						end
						SEQ_RD_SCL_HI: begin
							shift_byte = {shift_byte[BYTE_W-2:0], sda_in};
							if (bits_left != '0) bits_left = bits_left - 1'b1;
							step = SEQ_RD_SCL_LO;
						end
						SEQ_RD_SCL_LO: step = (bits_left != '0) ? SEQ_RD_SCL_HI : SEQ_RA_DRIVE;
						SEQ_RA_DRIVE:  step = SEQ_RA_SCL_HI;
						SEQ_RA_SCL_HI: step = SEQ_RA_CLOSE;
						SEQ_RA_CLOSE: begin
							read_hold = shift_byte;
							done      = 1'b1;
							step      = SEQ_IDLE;
						end
						default: begin
							done = 1'b1;
							step = SEQ_IDLE;
						end
					endcase
				end
			end

			t.scl   = scl_level;
			t.sda   = sda_level;
			t.en    = sda_en;
			t.busy  = busy;
			t.done  = done;
			t.rbyte = read_hold;
			t.ack   = ack_flag;
			expected_levels.push_back(t);
		endfunction

		function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		endfunction

		function void levels_seen(logic [OUT_TDATA_W-1:0] r);
			bus_tick_t want;
			bus_tick_t got;

			got.scl   = r[OUT_SCL_BIT];
			got.sda   = r[OUT_SDA_BIT];
			got.en    = r[OUT_EN_BIT];
			got.busy  = r[OUT_BUSY_BIT];
			got.done  = r[OUT_DONE_BIT];
			got.rbyte = r[OUT_RBYTE_LSB +: BYTE_W];
			got.ack   = r[OUT_ACK_BIT];
			if (expected_levels.size() == 0) begin
				mismatches++;
				$display("%0t: result item with none expected, expected nothing got %h", $time, r);
				return;
			end
			want = expected_levels.pop_front();
			compared++;
			compare_field("scl_drive",  BYTE_W'(want.scl),  BYTE_W'(got.scl));
			compare_field("sda_drive",  BYTE_W'(want.sda),  BYTE_W'(got.sda));
			compare_field("sda_enable", BYTE_W'(want.en),   BYTE_W'(got.en));
			compare_field("busy_res",   BYTE_W'(want.busy), BYTE_W'(got.busy));
			compare_field("done_res",   BYTE_W'(want.done), BYTE_W'(got.done));
			compare_field("read_byte",  want.rbyte,         got.rbyte);
			compare_field("ack_seen",   BYTE_W'(want.ack),  BYTE_W'(got.ack));
		endfunction
	endclass

endpackage

// ===== tb/sv/i2c_master_bit_engine_tb.sv =====
// Top of the I2C bit engine bench: clock, reset, tick driver, output stall process and test sequence.
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
	import i2cmbe_pkg::*;
	import i2cmbe_tb_pkg::*;

	localparam int RANDOM_BUSY_TICKS = 200;   // busy ticks wanted from the random part
	localparam int HOLD_CYCLES       = 300;   // long output stall, fills the block
	localparam int CYCLE_LIMIT       = 200000;
	localparam int IDLE_PERCENT      = 23;
	localparam int DRAIN_CYCLES      = 4;     // two pipeline stages, doubled

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [COUNT_W-1:0]     cfg_wdata = '0;

	bus_level_board board;

	// handshake pressure controls shared by the sender and the receiver
	bit quiet_run     = 1'b0;   // no idling on either side while set
	bit hold_request  = 1'b0;   // asks the receiver for one long stall
	int hold_left     = 0;
	int cycle_count   = 0;

	i2c_master_bit_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit: well past the slowest legal run, phase_ticks 255 stretches included
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				board.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request, none during the quiet stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (quiet_run) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// every result item goes to the scoreboard; values are those from before the edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.levels_seen(m_tdata);
	end

	// one tick of the bus sequencer; returns at the edge that took it
	task automatic send_tick(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] wbyte,
			logic nack, logic sda);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[IN_ACTION_LSB +: ACTION_W] = act;
		d[IN_WBYTE_LSB +: BYTE_W]    = wbyte;
		d[IN_NACK_BIT]               = nack;
		d[IN_SDA_BIT]                = sda;
		while (!quiet_run && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.tick_accepted(d);
	endtask

	// sender stops offering until every result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// the pipeline is empty here, though the sequencer may be mid-phase
	task automatic set_phase_ticks(logic [COUNT_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_phase_ticks(v);
	endtask

	// Issue a command and keep ticking until the sequencer is idle again. The filler
	// ticks carry random actions (all ignored while busy) and random SDA samples, which
	// become the slave ack or read data. retime_at >= 0 rewrites phase_ticks that many
	// ticks into the command.
	task automatic run_command(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] wbyte,
			logic nack, int retime_at, logic [COUNT_W-1:0] retime_val);
		int n;
		n = 0;
		send_tick(act, wbyte, nack, 1'($urandom_range(1)));
		while (board.is_busy()) begin
			if (n == retime_at)
				set_phase_ticks(retime_val);
			send_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
				1'($urandom_range(1)));
			n++;
		end
	endtask

	function automatic int pick_retime();
		return ($urandom_range(99) < 10) ? $urandom_range(8) : -1;
	endfunction

	// well-formed transfer: start, address byte, one to three data bytes, stop
	task automatic run_transfer();
		int n;
		int k;
		bit rd;
		n  = $urandom_range(1, 3);
		rd = ($urandom_range(1) == 1);
		run_command(ACT_START, 8'($urandom), 1'($urandom_range(1)), pick_retime(),
			8'($urandom_range(3)));
		run_command(ACT_WRITE, 8'($urandom), 1'($urandom_range(1)), pick_retime(),
			8'($urandom_range(3)));
		for (k = 0; k < n; k++) begin
			if (rd) begin
				// last read byte usually nacked, the rest usually acked
				run_command(ACT_READ, 8'($urandom),
					($urandom_range(9) == 0) ? 1'($urandom_range(1)) : (k == n - 1),
					pick_retime(), 8'($urandom_range(3)));
			end else begin
				run_command(ACT_WRITE, 8'($urandom), 1'($urandom_range(1)), pick_retime(),
					8'($urandom_range(3)));
			end
		end
		run_command(ACT_STOP, 8'($urandom), 1'($urandom_range(1)), pick_retime(),
			8'($urandom_range(3)));
	endtask

	initial begin
		int a;
		int base;
		int r;
		bit hold_done;

		board = new();
		hold_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// idle ticks show the reset levels; then a stop with nothing before it,
		// so SDA stays released while sda_drive follows the stop
		send_tick(ACT_NONE, 8'h00, 1'b0, 1'b1);
		send_tick(ACT_NONE, 8'hFF, 1'b1, 1'b0);
		run_command(ACT_STOP, 8'h00, 1'b0, -1, 8'd0);

		// ordinary transfer at the shortest phases, byte extremes and both nack choices
		run_command(ACT_START, 8'h00, 1'b0, -1, 8'd0);
		run_command(ACT_WRITE, 8'hA5, 1'b0, -1, 8'd0);
		run_command(ACT_WRITE, 8'hFF, 1'b1, -1, 8'd0);
		run_command(ACT_WRITE, 8'h00, 1'b0, -1, 8'd0);
		run_command(ACT_READ, 8'h00, 1'b0, -1, 8'd0);
		run_command(ACT_READ, 8'hFF, 1'b1, -1, 8'd0);
		run_command(ACT_STOP, 8'h00, 1'b0, -1, 8'd0);

		// spare action codes behave like none
		for (a = int'(ACT_UNUSED_FIRST); a <= int'(ACT_UNUSED_LAST); a++)
			send_tick(3'(a), 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));

		// commands out of protocol order just play their sequences
		run_command(ACT_WRITE, 8'h3C, 1'b0, -1, 8'd0);
		run_command(ACT_READ, 8'h00, 1'b1, -1, 8'd0);
		run_command(ACT_START, 8'h00, 1'b0, -1, 8'd0);
		run_command(ACT_START, 8'h00, 1'b0, -1, 8'd0);
		run_command(ACT_STOP, 8'h00, 1'b0, -1, 8'd0);
		run_command(ACT_STOP, 8'h00, 1'b0, -1, 8'd0);

		// one tick of extra hold per phase that follows phase_ticks
		set_phase_ticks(8'd1);
		run_command(ACT_START, 8'h00, 1'b0, -1, 8'd0);
		run_command(ACT_WRITE, 8'h81, 1'b0, -1, 8'd0);
		run_command(ACT_READ, 8'h00, 1'b1, -1, 8'd0);
		run_command(ACT_STOP, 8'h00, 1'b0, -1, 8'd0);

		// longest phases, then a start cut short: lowering phase_ticks below a count
		// already reached ends that phase at once
		set_phase_ticks(8'd255);
		run_command(ACT_START, 8'h00, 1'b0, 20, 8'd2);

		// raising phase_ticks mid-phase stretches the phase in progress
		set_phase_ticks(8'd0);
		run_command(ACT_READ, 8'h00, 1'b0, 3, 8'd3);
		set_phase_ticks(8'd0);

		// ---- random part ----
		base = board.busy_ticks;
		while (board.busy_ticks < base + RANDOM_BUSY_TICKS) begin
			// one long receiver stall while the sender keeps feeding a transfer,
			// then a transfer with no idling on either side
			if (!hold_done) begin
				hold_request = 1'b1;
				hold_done    = 1'b1;
				run_transfer();
				quiet_run = 1'b1;
				run_transfer();
				quiet_run = 1'b0;
				continue;
			end
			r = $urandom_range(99);
			if (r < 8) begin
				set_phase_ticks(($urandom_range(3) == 0) ? 8'($urandom_range(6)) :
					8'($urandom_range(2)));
			end else if (r < 14) begin
				// noise: any action code from idle, possibly starting a command
				run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
					-1, 8'd0);
			end else if (r < 20) begin
				// a lone command outside any transfer
				run_command(3'($urandom_range(int'(ACT_START), int'(ACT_READ))),
					8'($urandom), 1'($urandom_range(1)), pick_retime(),
					8'($urandom_range(3)));
			end else begin
				run_transfer();
			end
		end
		quiet_run = 1'b0;

		// ---- wrap up ----
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d bus ticks (%0d busy): %0d start, %0d stop, %0d write, %0d read.",
			board.compared, board.busy_ticks, board.starts, board.stops, board.writes,
			board.reads);
		$display("phase_ticks ran from 0 to 255 with mid-command changes and a %0d-cycle stall.",
			HOLD_CYCLES);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results missing", board.mismatches, board.pending());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
